>>> sv/pft_pkg.sv
package pft_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int PROCESS_COUNT_DEF = 2;

    localparam int CMD_W         = 3;
    localparam int PAGE_W        = 20;
    localparam int PID_W         = 1;
    localparam int PID_RANGE     = 2 ** PID_W;
    localparam int ENTRY_TOTAL_W = 5;
    localparam int WB_W          = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_FLUSH  = 3'd1,
        CMD_LOOKUP = 3'd2,
        CMD_MARK   = 3'd3,
        CMD_CLEAR  = 3'd4
    } pft_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PAGE_W-1:0] page;
        logic [PID_W-1:0]  pid;
    } pft_req_t;

    typedef struct packed {
        logic                     hit;
        logic                     full;
        logic [ENTRY_TOTAL_W-1:0] total;
    } pft_tbl_res_t;

endpackage

>>> sv/pft_table.sv
module pft_table
    import pft_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  pft_req_t     req,
    output pft_tbl_res_t res,
    output logic [CNT_W-1:0] dirty_n
);

    logic              valid_reg [TABLE_ENTRIES];
    logic [PAGE_W-1:0] page_reg  [TABLE_ENTRIES];
    logic [PID_W-1:0]  owner_reg [TABLE_ENTRIES];
    logic              dirty_reg [TABLE_ENTRIES];

    logic              valid_next [TABLE_ENTRIES];
    logic              ins_mask   [TABLE_ENTRIES];
    logic              page_eq    [TABLE_ENTRIES];
    logic              owner_eq   [TABLE_ENTRIES];

    always_comb
    begin
        logic             taken;
        logic             all_valid;
        logic             any_hit;
        logic [CNT_W-1:0] total_cnt;
        logic [CNT_W-1:0] dirty_cnt;
        taken     = 1'b0;
        all_valid = 1'b1;
        any_hit   = 1'b0;
        total_cnt = '0;
        dirty_cnt = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            ins_mask[i] = !valid_reg[i] && !taken;
            taken       = taken || !valid_reg[i];
            all_valid   = all_valid && valid_reg[i];
            page_eq[i]  = valid_reg[i] && (page_reg[i] == req.page);
            owner_eq[i] = valid_reg[i] && (owner_reg[i] == req.pid);
            any_hit     = any_hit || (page_eq[i] && owner_eq[i]);
            dirty_cnt   = dirty_cnt + CNT_W'(owner_eq[i] && dirty_reg[i]);
            case (req.cmd)
                CMD_INSERT: valid_next[i] = valid_reg[i] || ins_mask[i];
                CMD_FLUSH:  valid_next[i] = valid_reg[i] && !owner_eq[i];
                CMD_CLEAR:  valid_next[i] = 1'b0;
                default:    valid_next[i] = valid_reg[i];
            endcase
            total_cnt = total_cnt + CNT_W'(valid_next[i]);
        end
        res.hit   = (req.cmd == CMD_LOOKUP) && any_hit;
        res.full  = (req.cmd == CMD_INSERT) && all_valid;
        res.total = ENTRY_TOTAL_W'(total_cnt);
        dirty_n   = dirty_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (fire)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                valid_reg[i] <= valid_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (req.cmd == CMD_INSERT && ins_mask[i])
                begin
                    page_reg[i]  <= req.page;
                    owner_reg[i] <= req.pid;
                    dirty_reg[i] <= 1'b0;
                end
                else if (req.cmd == CMD_MARK && page_eq[i])
                begin
                    dirty_reg[i] <= 1'b1;
                end
            end
        end
    end

endmodule

>>> sv/pft_wb_ctr.sv
module pft_wb_ctr
    import pft_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int PROCESS_COUNT = PROCESS_COUNT_DEF,
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1),
    localparam int CTR_N = (PROCESS_COUNT < PID_RANGE) ? PROCESS_COUNT : PID_RANGE
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  pft_req_t         req,
    input  logic [CNT_W-1:0] dirty_n,
    output logic [WB_W-1:0]  wb_total
);

    logic [WB_W-1:0] ctr_reg  [CTR_N];
    logic [WB_W-1:0] ctr_next [CTR_N];

    always_comb
    begin
        wb_total = '0;
        for (int p = 0; p < CTR_N; p++)
        begin
            ctr_next[p] = ctr_reg[p];
            if (req.cmd == CMD_FLUSH && req.pid == PID_W'(p))
            begin
                ctr_next[p] = ctr_reg[p] + WB_W'(dirty_n);
            end
            if (req.pid == PID_W'(p))
            begin
                wb_total = ctr_next[p];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < CTR_N; p++)
            begin
                ctr_reg[p] <= '0;
            end
        end
        else if (fire)
        begin
            for (int p = 0; p < CTR_N; p++)
            begin
                ctr_reg[p] <= ctr_next[p];
            end
        end
    end

endmodule

>>> sv/page_frame_table_unit.sv
// Channel  | Handshake            | Fields
// request  | req_valid, req_stall | command, page_number, process_id
// response | rsp_valid, rsp_stall | hit, entry_total, writeback_total, status
//
// One command per cycle while no response stall holds the pipeline.
// The request register feeds one pass of table compare and update, whose
// result loads the response register while the table and counters update.
// Reset clears the valid bits and write-back counters at once; no sweep.
// A stalled response holds; the request register still takes a command
// while it is empty, so req_stall rises only when both stages are full.
module page_frame_table_unit
    import pft_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int PROCESS_COUNT = PROCESS_COUNT_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic [CMD_W-1:0]         command,
    input  logic [PAGE_W-1:0]        page_number,
    input  logic [PID_W-1:0]         process_id,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic                     hit,
    output logic [ENTRY_TOTAL_W-1:0] entry_total,
    output logic [WB_W-1:0]          writeback_total,
    output logic                     status
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic                     req_valid_reg;
    pft_req_t                 req_reg;
    logic                     rsp_valid_reg;
    logic                     hit_reg;
    logic [ENTRY_TOTAL_W-1:0] total_reg;
    logic [WB_W-1:0]          wb_reg;
    logic                     status_reg;

    logic                     fire;
    logic                     take;
    pft_tbl_res_t             tbl_res;
    logic [CNT_W-1:0]         dirty_n;
    logic [WB_W-1:0]          wb_total;

    assign fire      = req_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = req_valid_reg && !fire;
    assign take      = req_valid && !req_stall;

    pft_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .req     (req_reg),
        .res     (tbl_res),
        .dirty_n (dirty_n)
    );

    pft_wb_ctr #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .PROCESS_COUNT(PROCESS_COUNT)
    ) u_wb_ctr (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .req      (req_reg),
        .dirty_n  (dirty_n),
        .wb_total (wb_total)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                req_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                req_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg.cmd  <= command;
            req_reg.page <= page_number;
            req_reg.pid  <= process_id;
        end
        if (fire)
        begin
            hit_reg    <= tbl_res.hit;
            total_reg  <= tbl_res.total;
            wb_reg     <= wb_total;
            status_reg <= tbl_res.full;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign hit             = hit_reg;
    assign entry_total     = total_reg;
    assign writeback_total = wb_reg;
    assign status          = status_reg;

endmodule

>>> sv/pft_checker.sv
module pft_checker
    import pft_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_valid,
    input logic                     req_stall,
    input logic                     rsp_valid,
    input logic                     rsp_stall,
    input logic                     hit,
    input logic [ENTRY_TOTAL_W-1:0] entry_total,
    input logic                     status
);

    localparam bit TOTAL_FITS = TABLE_ENTRIES < (2 ** ENTRY_TOTAL_W);
    localparam logic [ENTRY_TOTAL_W-1:0] FULL_TOTAL = ENTRY_TOTAL_W'(TABLE_ENTRIES);

    // stalled response transaction stays up
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !TOTAL_FITS || (entry_total <= FULL_TOTAL))
        else $error("entry count beyond table size");

    // refused insert only on a full table
    a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status |-> !TOTAL_FITS || (entry_total == FULL_TOTAL))
        else $error("insert refused with free slot");

    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(hit && status))
        else $error("hit and refusal in one response");

    // request side never stalls with an idle response register
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !rsp_valid |-> !req_stall)
        else $error("request stalled with idle pipeline");

endmodule

bind page_frame_table_unit pft_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
) u_pft_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .hit         (hit),
    .entry_total (entry_total),
    .status      (status)
);
